>>> rtl/roi_wb_pkg.sv
// shared constants and types for the region writeback alignment block
package roi_wb_pkg;

	localparam int FACTOR_BITS = 11;
	localparam int STEP_BITS   = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int ADDR_BITS   = 5;
	localparam int DATA_BITS   = 32;

	localparam int FRAME_RIGHT_RESET  = 1920;
	localparam int FRAME_BOTTOM_RESET = 1080;
	localparam int ALIGN_RESET        = 256;

	localparam logic [2:0] REG_FRAME_LEFT   = 3'd0;
	localparam logic [2:0] REG_FRAME_TOP    = 3'd1;
	localparam logic [2:0] REG_FRAME_RIGHT  = 3'd2;
	localparam logic [2:0] REG_FRAME_BOTTOM = 3'd3;
	localparam logic [2:0] REG_ALIGN_FACTOR = 3'd4;

	typedef enum logic [1:0] {
		ACT_KEEP   = 2'd0,
		ACT_WIDTH  = 2'd1,
		ACT_HEIGHT = 2'd2,
		ACT_FRAME  = 2'd3
	} action_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} qstat_t;

endpackage

>>> rtl/roi_wb_mod.sv
// pipelined remainder unit, two dividend bits per stage
module roi_wb_mod #(
	parameter int XW = 28
) (
	input  logic                               clk,
	input  logic                               adv,
	input  logic [roi_wb_pkg::FACTOR_BITS-1:0] factor,
	input  logic [XW-1:0]                      x,
	output logic [roi_wb_pkg::FACTOR_BITS-1:0] rem
);
	import roi_wb_pkg::*;

	localparam int NST = (XW + STEP_BITS - 1) / STEP_BITS;
	localparam int PW  = NST * STEP_BITS;

	logic [FACTOR_BITS-1:0] rem_sm  [NST];
	logic [PW-1:0]          rest_sm [NST];

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic [FACTOR_BITS-1:0] rem_in;
		logic [FACTOR_BITS-1:0] rem_nx;
		logic [PW-1:0]          src;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign src    = PW'(x);
		end else begin : g_next
			assign rem_in = rem_sm[k-1];
			assign src    = rest_sm[k-1];
		end

		// shift in each of the stage's two bits, subtracting the factor once if it fits
		always_comb begin
			logic [FACTOR_BITS:0] tmp;
			rem_nx = rem_in;
			for (int i = 0; i < STEP_BITS; i++) begin
				tmp = {rem_nx, src[PW-1-i]};
				if (tmp >= {1'b0, factor}) begin
					tmp = tmp - {1'b0, factor};
				end
				rem_nx = tmp[FACTOR_BITS-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sm[k]  <= rem_nx;
				rest_sm[k] <= src << STEP_BITS;
			end
		end
	end

	assign rem = rem_sm[NST-1];

endmodule

>>> rtl/roi_wb_front.sv
// front pipeline: accepts regions, finds remainders and classifies each one
module roi_wb_front #(
	parameter int COORD_BITS = 14
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [COORD_BITS-1:0]              frame_left,
	input  logic [COORD_BITS-1:0]              frame_top,
	input  logic [COORD_BITS-1:0]              frame_right,
	input  logic [COORD_BITS-1:0]              frame_bottom,
	input  logic [roi_wb_pkg::FACTOR_BITS-1:0] factor,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [COORD_BITS-1:0]              in_left,
	input  logic [COORD_BITS-1:0]              in_top,
	input  logic [COORD_BITS-1:0]              in_right,
	input  logic [COORD_BITS-1:0]              in_bottom,
	input  roi_wb_pkg::qstat_t                 qstat,
	output logic                               ent_valid,
	output logic [5*COORD_BITS+1:0]            ent_data
);
	import roi_wb_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int PW  = 2 * CB;
	localparam int NST = (PW + STEP_BITS - 1) / STEP_BITS;
	localparam int DW  = 6 * CB;
	localparam int SW  = ((CB > FACTOR_BITS) ? CB : FACTOR_BITS) + 1;
	localparam int MW  = CB + FACTOR_BITS;

	logic adv;

	logic          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic          vm_sm [NST];
	logic [CB-1:0] l_s1, t_s1, r_s1, b_s1;
	logic [DW-1:0] pl_s2, pl_s3;
	logic [PW-1:0] p_s3;
	logic [DW-1:0] dly_sm [NST];

	logic [CB-1:0] w1, h1, w2, h2;

	logic [FACTOR_BITS-1:0] wr, hr, pr;
	logic [CB-1:0] l4, t4, r4, b4, w4, h4;
	logic [CB-1:0] fw, fh;
	logic [FACTOR_BITS-1:0] wx, hx;
	logic [SW-1:0] wsum, hsum;

	logic [4*CB-1:0]        box_s4, box_s5;
	logic [CB-1:0]          w_s4, h_s4, wm_s4, hm_s4, wm_s5, hm_s5;
	logic [FACTOR_BITS-1:0] wx_s4, hx_s4;
	logic                   cw_s4, ch_s4, keep_s4, cw_s5, ch_s5, keep_s5;
	logic [MW-1:0]          mw_s5, mh_s5;

	logic [5*CB+1:0] ent_nx, ent_s6;
	logic            use_h;
	action_t         act;

	assign adv      = !v_s6 || !qstat.full;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int k = 0; k < NST; k++) begin
				vm_sm[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			vm_sm[0] <= v_s3;
			for (int k = 1; k < NST; k++) begin
				vm_sm[k] <= vm_sm[k-1];
			end
			v_s4 <= vm_sm[NST-1];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// spans, an inverted edge pair counts as zero
	assign w1 = (r_s1 >= l_s1) ? r_s1 - l_s1 : '0;
	assign h1 = (b_s1 >= t_s1) ? b_s1 - t_s1 : '0;
	assign w2 = pl_s2[CB +: CB];
	assign h2 = pl_s2[0 +: CB];

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s1  <= in_left;
			t_s1  <= in_top;
			r_s1  <= in_right;
			b_s1  <= in_bottom;
			pl_s2 <= {l_s1, t_s1, r_s1, b_s1, w1, h1};
			pl_s3 <= pl_s2;
			p_s3  <= PW'(w2) * PW'(h2);
			dly_sm[0] <= pl_s3;
			for (int k = 1; k < NST; k++) begin
				dly_sm[k] <= dly_sm[k-1];
			end
		end
	end

	roi_wb_mod #(.XW(PW)) u_mod_p (
		.clk(clk), .adv(adv), .factor(factor), .x(p_s3), .rem(pr)
	);
	roi_wb_mod #(.XW(PW)) u_mod_w (
		.clk(clk), .adv(adv), .factor(factor), .x(PW'(pl_s3[CB +: CB])), .rem(wr)
	);
	roi_wb_mod #(.XW(PW)) u_mod_h (
		.clk(clk), .adv(adv), .factor(factor), .x(PW'(pl_s3[0 +: CB])), .rem(hr)
	);

	assign {l4, t4, r4, b4, w4, h4} = dly_sm[NST-1];

	assign fw   = (frame_right >= frame_left) ? frame_right - frame_left : '0;
	assign fh   = (frame_bottom >= frame_top) ? frame_bottom - frame_top : '0;
	assign wx   = factor - wr;
	assign hx   = factor - hr;
	assign wsum = SW'(w4) + SW'(wx);
	assign hsum = SW'(h4) + SW'(hx);

	always_ff @(posedge clk) begin
		if (adv) begin
			box_s4  <= {l4, t4, r4, b4};
			w_s4    <= w4;
			h_s4    <= h4;
			wx_s4   <= wx;
			hx_s4   <= hx;
			cw_s4   <= wsum <= SW'(fw);
			ch_s4   <= hsum <= SW'(fh);
			wm_s4   <= wsum[CB-1:0];
			hm_s4   <= hsum[CB-1:0];
			keep_s4 <= (pr == '0) ||
				((l4 == frame_left) && (t4 == frame_top) &&
				 (r4 == frame_right) && (b4 == frame_bottom));

			box_s5  <= box_s4;
			wm_s5   <= wm_s4;
			hm_s5   <= hm_s4;
			cw_s5   <= cw_s4;
			ch_s5   <= ch_s4;
			keep_s5 <= keep_s4;
			mw_s5   <= MW'(wx_s4) * MW'(h_s4);
			mh_s5   <= MW'(hx_s4) * MW'(w_s4);

			ent_s6  <= ent_nx;
		end
	end

	// height wins when width growth does not fit, or when both fit and height adds fewer pixels; a tie goes to width
	assign use_h = !cw_s5 || (ch_s5 && (mw_s5 > mh_s5));

	always_comb begin
		if (keep_s5) begin
			act    = ACT_KEEP;
			ent_nx = {box_s5, {CB{1'b0}}, ACT_KEEP};
		end else if (!cw_s5 && !ch_s5) begin
			act    = ACT_FRAME;
			ent_nx = {frame_left, frame_top, frame_right, frame_bottom, {CB{1'b0}}, ACT_FRAME};
		end else if (use_h) begin
			act    = ACT_HEIGHT;
			ent_nx = {box_s5, hm_s5, ACT_HEIGHT};
		end else begin
			act    = ACT_WIDTH;
			ent_nx = {box_s5, wm_s5, ACT_WIDTH};
		end
		ent_nx[1:0] = act;
	end

	assign ent_valid = v_s6;
	assign ent_data  = ent_s6;

endmodule

>>> rtl/roi_wb_queue.sv
// short queue between the classifying front and the expanding back
module roi_wb_queue #(
	parameter int W = 72
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_req,
	input  logic [W-1:0]       wr_data,
	input  logic               pop,
	output logic [W-1:0]       rd_data,
	output roi_wb_pkg::qstat_t qstat
);
	import roi_wb_pkg::*;

	localparam int PB = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]  mem_q [QUEUE_DEPTH];
	logic [PB-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, full;

	assign full = count_q == CW'(QUEUE_DEPTH);
	assign push = push_req && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PB'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PB'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data         = mem_q[rd_ptr_q];
	assign qstat.full      = full;
	assign qstat.not_empty = count_q != '0;

endmodule

>>> rtl/roi_wb_back.sv
// back stage: centres and clamps the chosen expansion, holds the result beat
module roi_wb_back #(
	parameter int COORD_BITS = 14
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [COORD_BITS-1:0]   frame_right,
	input  logic [COORD_BITS-1:0]   frame_bottom,
	input  logic [5*COORD_BITS+1:0] ent_data,
	input  roi_wb_pkg::qstat_t      qstat,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [COORD_BITS-1:0]   out_left,
	output logic [COORD_BITS-1:0]   out_top,
	output logic [COORD_BITS-1:0]   out_right,
	output logic [COORD_BITS-1:0]   out_bottom,
	output logic [1:0]              action
);
	import roi_wb_pkg::*;

	localparam int CB = COORD_BITS;

	logic [CB-1:0] l, t, r, b, m;
	logic [1:0]    act;
	logic          horiz;
	logic [CB-1:0] s, e, bound, len, c, half, st, en;
	logic [CB:0]   en_raw;
	logic [CB-1:0] nl, nt, nr, nb;

	logic          out_valid_q;
	logic [CB-1:0] l_q, t_q, r_q, b_q;
	logic [1:0]    act_q;

	assign {l, t, r, b, m, act} = ent_data;

	assign horiz = act == ACT_WIDTH;
	assign s     = horiz ? l : t;
	assign e     = horiz ? r : b;
	assign bound = horiz ? frame_right : frame_bottom;
	assign len   = e - s;
	assign c     = m - len;
	assign half  = c >> 1;
	assign en_raw = {1'b0, e} + {1'b0, half} + (CB+1)'(c[0]);

	// centred growth, pushed back inside when it runs below zero or past the frame's right or bottom edge
	always_comb begin
		if (s < half) begin
			st = '0;
			en = m;
		end else if (en_raw > {1'b0, bound}) begin
			st = bound - m;
			en = bound;
		end else begin
			st = s - half;
			en = en_raw[CB-1:0];
		end
	end

	always_comb begin
		nl = l;
		nt = t;
		nr = r;
		nb = b;
		case (act)
			ACT_WIDTH: begin
				nl = st;
				nr = en;
			end
			ACT_HEIGHT: begin
				nt = st;
				nb = en;
			end
			default: begin
			end
		endcase
	end

	assign pop = qstat.not_empty && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= qstat.not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			l_q   <= nl;
			t_q   <= nt;
			r_q   <= nr;
			b_q   <= nb;
			act_q <= act;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_left   = l_q;
	assign out_top    = t_q;
	assign out_right  = r_q;
	assign out_bottom = b_q;
	assign action     = act_q;

endmodule

>>> rtl/roi_writeback_alignment_top.sv
// top level of the region writeback alignment block with its register port
// Takes one region (left, top, right, bottom; right and bottom exclusive) per beat and
// returns it unchanged, grown in width or height to meet the alignment factor, or
// replaced by the full frame, with action telling which. A new region is taken every
// cycle unless in_stall is raised. The remainder pipeline works through the
// 2*COORD_BITS-bit pixel count two bits per stage. A four-entry queue sits between
// the classifying front pipeline and the expansion stage, so a stalled output holds
// the front back only once it fills. Registers at byte address 4*i: frame_left,
// frame_top, frame_right, frame_bottom, align_factor; an align_factor of zero acts
// as one. Write them only while idle.
module roi_writeback_alignment_top #(
	parameter int COORD_BITS = 14
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [roi_wb_pkg::ADDR_BITS-1:0] paddr,
	input  logic [roi_wb_pkg::DATA_BITS-1:0] pwdata,
	output logic [roi_wb_pkg::DATA_BITS-1:0] prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [COORD_BITS-1:0]            in_left,
	input  logic [COORD_BITS-1:0]            in_top,
	input  logic [COORD_BITS-1:0]            in_right,
	input  logic [COORD_BITS-1:0]            in_bottom,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [COORD_BITS-1:0]            out_left,
	output logic [COORD_BITS-1:0]            out_top,
	output logic [COORD_BITS-1:0]            out_right,
	output logic [COORD_BITS-1:0]            out_bottom,
	output logic [1:0]                       action
);
	import roi_wb_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int EW = 5 * CB + 2;

	logic [CB-1:0]          frame_left_q, frame_top_q, frame_right_q, frame_bottom_q;
	logic [FACTOR_BITS-1:0] align_q, factor;
	logic [2:0]             reg_idx;
	logic                   wr_en;

	logic          ent_valid, pop;
	logic [EW-1:0] ent_data, q_data;
	qstat_t        qstat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_left_q   <= '0;
			frame_top_q    <= '0;
			frame_right_q  <= CB'(FRAME_RIGHT_RESET);
			frame_bottom_q <= CB'(FRAME_BOTTOM_RESET);
			align_q        <= FACTOR_BITS'(ALIGN_RESET);
		end else if (wr_en) begin
			case (reg_idx)
				REG_FRAME_LEFT:   frame_left_q   <= pwdata[CB-1:0];
				REG_FRAME_TOP:    frame_top_q    <= pwdata[CB-1:0];
				REG_FRAME_RIGHT:  frame_right_q  <= pwdata[CB-1:0];
				REG_FRAME_BOTTOM: frame_bottom_q <= pwdata[CB-1:0];
				REG_ALIGN_FACTOR: align_q        <= pwdata[FACTOR_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FRAME_LEFT:   prdata = DATA_BITS'(frame_left_q);
			REG_FRAME_TOP:    prdata = DATA_BITS'(frame_top_q);
			REG_FRAME_RIGHT:  prdata = DATA_BITS'(frame_right_q);
			REG_FRAME_BOTTOM: prdata = DATA_BITS'(frame_bottom_q);
			REG_ALIGN_FACTOR: prdata = DATA_BITS'(align_q);
			default:          prdata = '0;
		endcase
	end

	assign factor = (align_q == '0) ? FACTOR_BITS'(1) : align_q;

	roi_wb_front #(.COORD_BITS(CB)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_left   (frame_left_q),
		.frame_top    (frame_top_q),
		.frame_right  (frame_right_q),
		.frame_bottom (frame_bottom_q),
		.factor       (factor),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_left      (in_left),
		.in_top       (in_top),
		.in_right     (in_right),
		.in_bottom    (in_bottom),
		.qstat        (qstat),
		.ent_valid    (ent_valid),
		.ent_data     (ent_data)
	);

	roi_wb_queue #(.W(EW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_req (ent_valid),
		.wr_data  (ent_data),
		.pop      (pop),
		.rd_data  (q_data),
		.qstat    (qstat)
	);

	roi_wb_back #(.COORD_BITS(CB)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_right  (frame_right_q),
		.frame_bottom (frame_bottom_q),
		.ent_data     (q_data),
		.qstat        (qstat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_left     (out_left),
		.out_top      (out_top),
		.out_right    (out_right),
		.out_bottom   (out_bottom),
		.action       (action)
	);

`ifndef SYNTHESIS
	// the input side only backs up once the queue is full
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> qstat.full)
		else $error("input stalled while queue has room");

	// a waiting result beat must never be overwritten by a queue read
	a_no_pop_over_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !pop)
		else $error("queue read while result beat is held");
`endif

endmodule
